### hw/rtl/shes_pkg.sv
// ----------------------------------------------------------------------------
// shes_pkg
// Widths, register indexes and reset values shared by the horizontal Sobel
// edge stream and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package shes_pkg;

  localparam int PIXEL_W    = 8;
  localparam int SUM_W      = 11;
  localparam int BYTE_W     = 8;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;

endpackage

`default_nettype wire

### hw/rtl/sobel_horizontal_edge_stream.sv
// ----------------------------------------------------------------------------
// sobel_horizontal_edge_stream
// 3x3 horizontal Sobel filter (1 2 1 / 0 0 0 / -1 -2 -1) over a raster
// pixel stream, zero padded above and to the left.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock while stage 1 is not held by a stalled
// output. The result for centre (y-1,x-1) comes from pixel (y,x): stage 0
// reads both line stores (dual-port memories, one write and one registered
// read port each), stage 1 forms the sum into the output register. Rows 0
// and column 0 give no result; a frame gives (height-1)*(width-1) beats, the
// final one with tlast set. Width is clamped to 2..MAX_WIDTH, height raised
// to at least 2. The line stores hold no defined content until the first two
// rows of a frame have passed; the top row reads as zero until then.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_horizontal_edge_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire                               clk,
  input  wire                               rst,
  // tdata: pixel[7:0]
  input  wire [shes_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: edge_sum[10:0], edge_byte[18:11], zero fill[23:19]
  output logic [shes_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tlast: frame_last
  output logic                              m_axis_tlast,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [shes_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [shes_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import shes_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
  localparam logic [WW-1:0] W_MIN = WW'(2);
  localparam logic [FH_W-1:0] H_MIN = FH_W'(2);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;

  logic [PIXEL_W-1:0] older_row_store    [MAX_WIDTH];
  logic [PIXEL_W-1:0] previous_row_store [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_prev;
  logic [PIXEL_W-1:0] rd_older;

  logic [CW-1:0]   column_position;
  logic [FH_W-1:0] row_position;

  logic [PIXEL_W-1:0] top_window    [2];
  logic [PIXEL_W-1:0] bottom_window [2];

  typedef struct packed {
    logic [PIXEL_W-1:0] px;
    logic [CW-1:0]      x;
    logic               top_valid;
    logic               emit;
    logic               last;
    logic               first;
  } stage_t;

  stage_t s1;
  logic   s1_valid;

  logic              in_acc;
  logic              s1_adv;
  logic [WW-1:0]     w_ext;
  logic [WW-1:0]     w_use;
  logic [FH_W-1:0]   h_use;
  logic              last_col;
  logic              last_row;

  logic [PIXEL_W-1:0] top;
  logic [PIXEL_W-1:0] tw0;
  logic [PIXEL_W-1:0] tw1;
  logic [PIXEL_W-1:0] bw0;
  logic [PIXEL_W-1:0] bw1;
  logic [SUM_W-2:0]   t_sum;
  logic [SUM_W-2:0]   b_sum;
  logic [SUM_W-1:0]   s_sum;

  logic [SUM_W-1:0]   edge_sum;
  logic [BYTE_W-1:0]  edge_byte;
  logic               frame_last;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // geometry
  always_comb begin
    w_ext = WW'(frame_width);
    if (w_ext < W_MIN) begin
      w_use = W_MIN;
    end else if (w_ext > W_MAX) begin
      w_use = W_MAX;
    end else begin
      w_use = w_ext;
    end
    h_use    = (frame_height < H_MIN) ? H_MIN : frame_height;
    last_col = WW'(column_position) >= (w_use - WW'(1));
    last_row = row_position >= (h_use - FH_W'(1));
  end

  // handshake
  assign s1_adv        = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // stage 0: position counters and line store reads
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        column_position <= '0;
        row_position    <= last_row ? '0 : row_position + FH_W'(1);
      end else begin
        column_position <= column_position + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_prev  <= previous_row_store[column_position];
      rd_older <= older_row_store[column_position];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1.px        <= s_axis_tdata[PIXEL_W-1:0];
      s1.x         <= column_position;
      s1.top_valid <= row_position >= FH_W'(2);
      s1.emit      <= (row_position != '0) && (column_position != '0);
      s1.last      <= last_col && last_row;
      s1.first     <= column_position == '0;
    end
  end

  // stage 1: kernel sum, line store writes, window shift
  always_comb begin
    top   = s1.top_valid ? rd_older : '0;
    tw0   = s1.first ? '0 : top_window[0];
    tw1   = s1.first ? '0 : top_window[1];
    bw0   = s1.first ? '0 : bottom_window[0];
    bw1   = s1.first ? '0 : bottom_window[1];
    t_sum = (SUM_W-1)'(tw0) + {1'b0, tw1, 1'b0} + (SUM_W-1)'(top);
    b_sum = (SUM_W-1)'(bw0) + {1'b0, bw1, 1'b0} + (SUM_W-1)'(s1.px);
    s_sum = {1'b0, t_sum} - {1'b0, b_sum};
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      older_row_store[s1.x]    <= rd_prev;
      previous_row_store[s1.x] <= s1.px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_window[0]    <= '0;
      top_window[1]    <= '0;
      bottom_window[0] <= '0;
      bottom_window[1] <= '0;
    end else if (s1_adv) begin
      top_window[0]    <= tw1;
      top_window[1]    <= top;
      bottom_window[0] <= bw1;
      bottom_window[1] <= s1.px;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_axis_tvalid <= s1.emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      edge_sum   <= s_sum;
      edge_byte  <= s_sum[BYTE_W-1:0];
      frame_last <= s1.last;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - SUM_W - BYTE_W)'(0), edge_byte, edge_sum};
  assign m_axis_tlast = frame_last;

endmodule

`default_nettype wire

### hw/rtl/shes_checker.sv
// ----------------------------------------------------------------------------
// shes_checker
// Port-level checks on the horizontal Sobel edge stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module shes_checker (
  input wire                               clk,
  input wire                               rst,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [shes_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire                               m_axis_tlast
);
  import shes_pkg::*;

  logic in_acc;
  logic pad_ok;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign pad_ok = m_axis_tdata[OUT_TDATA_W-1:SUM_W+BYTE_W] == '0;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // input backpressure only comes from a stalled output
  a_ready_src: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a fresh result follows an accepted pixel through stage 1 and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_acc, 2))
    else $error("result without a pixel two cycles earlier");

  // reset leaves the pipeline empty
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipeline not empty after reset");

  // byte field is the low bits of the sum, fill is zero
  a_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      pad_ok && (m_axis_tdata[SUM_W+BYTE_W-1:SUM_W] == m_axis_tdata[BYTE_W-1:0]))
    else $error("edge byte does not match edge sum");

endmodule

bind sobel_horizontal_edge_stream shes_checker u_shes_checker (.*);

`default_nettype wire
